// ===== hdl/wve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wve_pkg
// Shared widths, reset values, register indexes and types for the weighted
// voting ensemble.
// ----------------------------------------------------------------------------
package wve_pkg;

  // Field widths
  localparam int SCORE_W     = 16;
  localparam int WEIGHT_W    = 24;
  localparam int TRADE_W     = 12;
  localparam int RAISE_W     = SCORE_W + TRADE_W - 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int FIELD_LANES = 4;

  // Q1.15 one
  localparam logic [SCORE_W-1:0] SCORE_ONE = 16'h8000;

  // Reset values
  localparam logic [SCORE_W-1:0]         THRESHOLD_RST = 16'd16384;
  localparam logic [SCORE_W-1:0]         STEP_RST      = 16'd655;
  localparam logic [TRADE_W-1:0]         TRADEOFF_RST  = 12'd256;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_RST    = 24'sd32768;

  // Saturation limits
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 24'sh7FFFFF;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 24'sh800000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD,
    CFG_STEP,
    CFG_TRADEOFF,
    CFG_WEIGHT_A,
    CFG_WEIGHT_B,
    CFG_WEIGHT_C,
    CFG_WEIGHT_D
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_UPD
  } wve_state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic               done;
    logic               fault;
    logic [SCORE_W-1:0] quot;
  } div_stat_t;

  // Scores above one count as one
  function automatic logic [SCORE_W-1:0] clamp_score(input logic [SCORE_W-1:0] s);
    logic [SCORE_W-1:0] r;
    r = s[SCORE_W-1] ? SCORE_ONE : s;
    return r;
  endfunction

endpackage

// ===== hdl/wve_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wve_in_if / wve_out_if
// Valid/ready channels for score items and ensemble results.
// ----------------------------------------------------------------------------
interface wve_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        is_spam;
  logic [15:0] score_a;
  logic [15:0] score_b;
  logic [15:0] score_c;
  logic [15:0] score_d;

  modport source (output valid, func, is_spam, score_a, score_b, score_c, score_d,
                  input ready);
  modport sink   (input valid, func, is_spam, score_a, score_b, score_c, score_d,
                  output ready);
endinterface

interface wve_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] ensemble_score;
  logic        verdict;
  logic        weight_fault;

  modport source (output valid, ensemble_score, verdict, weight_fault, input ready);
  modport sink   (input valid, ensemble_score, verdict, weight_fault, output ready);
endinterface

// ===== hdl/wve_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wve_mac
// Bit-serial weighted sum: scores shift out MSB first, one bit per cycle, and
// the selected weights are added into a doubling accumulator.
// ----------------------------------------------------------------------------
module wve_mac
  import wve_pkg::*;
#(
  parameter int LANES = 4,
  parameter int NUM_W = 41
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [SCORE_W-1:0]         score  [LANES],
  input  logic signed [WEIGHT_W-1:0] weight [LANES],
  output logic signed [NUM_W-1:0]    num,
  output logic                       done
);

  localparam int CNT_W = $clog2(SCORE_W);

  logic [SCORE_W-1:0]      sh_r [LANES];
  logic signed [NUM_W-1:0] acc_r, acc_nxt, partial;
  logic [CNT_W-1:0]        cnt_r;
  logic                    busy_r;
  logic                    done_r;

  // Sum of weights whose score bit is set, then shift-add
  always_comb begin
    partial = '0;
    for (int i = 0; i < LANES; i++) begin
      if (sh_r[i][SCORE_W-1]) partial = partial + NUM_W'(weight[i]);
    end
    acc_nxt = (acc_r <<< 1) + partial;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(SCORE_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SCORE_W - 1)) busy_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      for (int i = 0; i < LANES; i++) sh_r[i] <= score[i];
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      for (int i = 0; i < LANES; i++) sh_r[i] <= sh_r[i] << 1;
    end
  end

  assign num  = acc_r;
  assign done = done_r;

endmodule

// ===== hdl/wve_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wve_div
// Restoring divider, one quotient bit per cycle, with the range checks for a
// non-positive weight sum, a negative average and an average above one.
// ----------------------------------------------------------------------------
module wve_div
  import wve_pkg::*;
#(
  parameter int NUM_W = 41,
  parameter int DEN_W = 26
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output div_stat_t               stat
);

  localparam int CNT_W = $clog2(SCORE_W);

  logic [DEN_W-1:0]   den_u;
  logic [NUM_W-1:0]   den_top;
  logic               bad, over;
  logic [NUM_W-1:0]   rem_r, dsh_r;
  logic [SCORE_W-1:0] q_r;
  logic               bad_r, over_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r, done_r;
  logic               ge;

  // Start checks: divisor aligned to the top quotient bit
  always_comb begin
    den_u   = den;
    den_top = NUM_W'(den_u) << (SCORE_W - 1);
    bad     = den[DEN_W-1] || (den == '0) || num[NUM_W-1];
    over    = unsigned'(num) > den_top;
    ge      = rem_r >= dsh_r;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(SCORE_W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SCORE_W - 1)) busy_r <= 1'b0;
      end
    end
  end

  // Compare-subtract step
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= unsigned'(num);
      dsh_r  <= den_top;
      q_r    <= '0;
      bad_r  <= bad;
      over_r <= over;
    end else if (busy_r) begin
      rem_r <= ge ? rem_r - dsh_r : rem_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[SCORE_W-2:0], ge};
    end
  end

  // Result with clamping
  always_comb begin
    stat.done  = done_r;
    stat.fault = bad_r || over_r;
    if (bad_r)       stat.quot = '0;
    else if (over_r) stat.quot = SCORE_ONE;
    else             stat.quot = q_r;
  end

endmodule

// ===== hdl/weighted_vote_ensemble_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_vote_ensemble_update
// Weighted voting ensemble with online weight update.
// ----------------------------------------------------------------------------
// One item is worked on at a time: after a transfer on in_ch the lane scores
// are multiplied into the weights one score bit per cycle, then a restoring
// divider produces the average one quotient bit per cycle, and a final step
// writes the result register and, for training items, the weights. The next
// item is taken only back in the idle state, once the last one is committed.
// A finished result waits in the output register without holding back the
// next item; a result still waiting there when the following one is finished
// stalls that one in its last step.
// Writing an initial weight register also loads that lane's vote weight.
// ----------------------------------------------------------------------------
module weighted_vote_ensemble_update
  import wve_pkg::*;
#(
  parameter int LANE_COUNT = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wve_in_if.sink                in_ch,
  wve_out_if.source             out_ch
);

  localparam int LANES = (LANE_COUNT < FIELD_LANES) ? LANE_COUNT : FIELD_LANES;
  localparam int LW    = $clog2(LANES);
  localparam int DEN_W = WEIGHT_W + LW;
  localparam int NUM_W = WEIGHT_W + SCORE_W - 1 + LW;

  // Configuration and state
  logic [SCORE_W-1:0]         thr_r, step_r;
  logic [TRADE_W-1:0]         trade_r;
  logic [RAISE_W-1:0]         raise_r;
  logic signed [WEIGHT_W-1:0] weight_r [LANES];
  logic signed [WEIGHT_W-1:0] weight_upd [LANES];
  logic signed [WEIGHT_W:0]   wide [LANES];

  // Item registers
  logic [SCORE_W-1:0] score_in [FIELD_LANES];
  logic [SCORE_W-1:0] score_cl [LANES];
  logic [SCORE_W-1:0] sc_r [LANES];
  logic               func_r, spam_r;

  // Sequencer
  wve_state_t state_r, state_nxt;
  logic       accept, mac_start, div_start, commit;

  // Datapath links
  logic signed [NUM_W-1:0] num;
  logic signed [DEN_W-1:0] den;
  logic                    mac_done;
  div_stat_t               dstat;
  logic                    verdict;

  // Output register
  logic               out_valid_r;
  logic [SCORE_W-1:0] ens_r;
  logic               verdict_r, fault_r;

  assign score_in[0] = in_ch.score_a;
  assign score_in[1] = in_ch.score_b;
  assign score_in[2] = in_ch.score_c;
  assign score_in[3] = in_ch.score_d;

  always_comb begin
    for (int i = 0; i < LANES; i++) score_cl[i] = clamp_score(score_in[i]);
  end

  // Scalar configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESHOLD_RST;
      step_r  <= STEP_RST;
      trade_r <= TRADEOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r   <= cfg_data[SCORE_W-1:0];
        CFG_STEP:      step_r  <= cfg_data[SCORE_W-1:0];
        CFG_TRADEOFF:  trade_r <= cfg_data[TRADE_W-1:0];
        default: ;
      endcase
    end
  end

  // Raise amount, Q5.15 truncated
  always_ff @(posedge clk) begin
    raise_r <= RAISE_W'((SCORE_W + TRADE_W)'(trade_r) * (SCORE_W + TRADE_W)'(step_r) >> 8);
  end

  // Weight sum
  always_comb begin
    den = '0;
    for (int i = 0; i < LANES; i++) den = den + DEN_W'(weight_r[i]);
  end

  // Ensemble verdict
  assign verdict = dstat.quot > thr_r;

  // Per-lane training step with saturation
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      wide[i] = (WEIGHT_W + 1)'(weight_r[i]);
      if (verdict ? !(sc_r[i] > thr_r) : (sc_r[i] > thr_r)) begin
        if (spam_r ^ verdict)
          wide[i] = wide[i] + $signed({{(WEIGHT_W + 1 - RAISE_W){1'b0}}, raise_r});
        else
          wide[i] = wide[i] - $signed({{(WEIGHT_W + 1 - SCORE_W){1'b0}}, step_r});
      end
      if (wide[i][WEIGHT_W] != wide[i][WEIGHT_W-1])
        weight_upd[i] = wide[i][WEIGHT_W] ? WEIGHT_MIN : WEIGHT_MAX;
      else
        weight_upd[i] = wide[i][WEIGHT_W-1:0];
    end
  end

  // Vote weights
  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (!rst_n)
        weight_r[i] <= WEIGHT_RST;
      else if (commit && func_r)
        weight_r[i] <= weight_upd[i];
      else if (cfg_we && (cfg_index == CFG_IDX_W'(int'(CFG_WEIGHT_A) + i)))
        weight_r[i] <= cfg_data[WEIGHT_W-1:0];
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_ch.func;
      spam_r <= in_ch.is_spam;
      for (int i = 0; i < LANES; i++) sc_r[i] <= score_cl[i];
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    div_start = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        accept = in_ch.valid;
        if (in_ch.valid) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mac_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dstat.done) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!out_valid_r || out_ch.ready) begin
          commit    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign mac_start   = accept;

  wve_mac #(
    .LANES (LANES),
    .NUM_W (NUM_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mac_start),
    .score  (score_cl),
    .weight (weight_r),
    .num    (num),
    .done   (mac_done)
  );

  wve_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .stat  (dstat)
  );

  // Output register: valid holds until the transfer
  always_ff @(posedge clk) begin
    if (!rst_n)              out_valid_r <= 1'b0;
    else if (commit)         out_valid_r <= 1'b1;
    else if (out_ch.ready)   out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      ens_r     <= dstat.quot;
      verdict_r <= verdict;
      fault_r   <= dstat.fault;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ensemble_score = ens_r;
  assign out_ch.verdict        = verdict_r;
  assign out_ch.weight_fault   = fault_r;

endmodule
